@@ rtl/core/char_lcd_nibble_write_sequencer_unit_defines.svh @@
// Assertion macros used by the checker file of the LCD sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define LCDNS_CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also looks at the reset cycles.
`define LCDNS_CHK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/lcdns_pkg.sv @@
`timescale 1ns / 1ps
package lcdns_pkg;

    // Request type codes.
    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_CMD    = 3'd1;
    localparam logic [2:0] REQ_DATA   = 3'd2;
    localparam logic [2:0] REQ_CURSOR = 3'd3;
    localparam logic [2:0] REQ_DEC    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FUNC_SET  = 2'd0;
    localparam logic [1:0] CFG_DISP_CTRL = 2'd1;
    localparam logic [1:0] CFG_ENTRY     = 2'd2;

    // Fixed command bytes and timing.
    localparam logic [7:0] CMD_FUNC_RST  = 8'h28;
    localparam logic [7:0] CMD_DISP_RST  = 8'h0E;
    localparam logic [7:0] CMD_ENTRY_RST = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h80;
    localparam logic [7:0] CMD_ROW2      = 8'h40;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] PULSE_HOLD    = 8'd2;
    localparam logic [7:0] CMD_WAIT      = 8'd250;
    localparam logic [13:0] DEC_MAX      = 14'd9999;
    localparam int DEF_MAX_COLUMNS       = 40;

    // Microprogram entry points.
    localparam logic [4:0] UA_INIT      = 5'd0;
    localparam logic [4:0] UA_INIT_BYTE = 5'd10;
    localparam logic [4:0] UA_BYTE      = 5'd15;
    localparam logic [4:0] UA_DEC       = 5'd20;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  byte_value;
        logic [7:0]  column;
        logic        row;
        logic [13:0] number;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic       enable;
        logic [3:0] nibble;
        logic [7:0] hold_units;
        logic       last;
    } t_rslt;

    typedef struct packed {
        logic [7:0] func_set;
        logic [7:0] disp_ctrl;
        logic [7:0] entry_mode;
    } t_cfg;

    // Launch of a microprogram from the request decoder.
    typedef struct packed {
        logic       go;
        logic [4:0] entry;
        logic       rs;
        logic [7:0] req_byte;
    } t_start;

    typedef enum logic [1:0] {
        OP_NEXT = 2'd0,
        OP_END  = 2'd1,
        OP_LOOP = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        NS_CONST = 2'd0,
        NS_HI    = 2'd1,
        NS_LO    = 2'd2
    } t_nsel;

    typedef enum logic [1:0] {
        SRC_REQ   = 2'd0,
        SRC_INIT  = 2'd1,
        SRC_DIGIT = 2'd2
    } t_src;

    // One control word of the microprogram.
    typedef struct packed {
        t_op        op;
        logic       en;
        t_nsel      nsel;
        t_src       src;
        logic [3:0] nconst;
        logic [7:0] hold;
        logic [4:0] target;
        logic [2:0] lim;
    } t_uword;

    // Pin state with a fixed nibble, used by the wake-up part of init.
    function automatic t_uword uc_raw(logic en, logic [3:0] nib, logic [7:0] hold);
        t_uword w;
        w        = '0;
        w.op     = OP_NEXT;
        w.en     = en;
        w.nsel   = NS_CONST;
        w.src    = SRC_REQ;
        w.nconst = nib;
        w.hold   = hold;
        return w;
    endfunction

    // One of the five pin states of a byte transfer.
    function automatic t_uword uc_body(logic [2:0] ofs, t_src src, logic [7:0] tail,
                                       t_op op, logic [4:0] tgt, logic [2:0] lim);
        t_uword w;
        w        = '0;
        w.op     = OP_NEXT;
        w.src    = src;
        w.target = tgt;
        w.lim    = lim;
        case (ofs)
            3'd0: begin
                w.en = 1'b0; w.nsel = NS_HI; w.hold = 8'd0;
            end
            3'd1: begin
                w.en = 1'b1; w.nsel = NS_HI; w.hold = PULSE_HOLD;
            end
            3'd2: begin
                w.en = 1'b0; w.nsel = NS_LO; w.hold = 8'd0;
            end
            3'd3: begin
                w.en = 1'b1; w.nsel = NS_LO; w.hold = PULSE_HOLD;
            end
            default: begin
                w.en = 1'b0; w.nsel = NS_LO; w.hold = tail; w.op = op;
            end
        endcase
        return w;
    endfunction

    // Control store: init wake-up, init command loop, single byte, decimal loop.
    function automatic t_uword uc_rom(logic [4:0] addr);
        t_uword w;
        w = uc_raw(1'b0, 4'h0, 8'd0);
        case (addr)
            5'd0: w = uc_raw(1'b0, 4'h3, 8'd40);
            5'd1: w = uc_raw(1'b1, 4'h3, 8'd0);
            5'd2: w = uc_raw(1'b0, 4'h3, 8'd5);
            5'd3: w = uc_raw(1'b1, 4'h3, 8'd0);
            5'd4: w = uc_raw(1'b0, 4'h3, 8'd5);
            5'd5: w = uc_raw(1'b1, 4'h3, 8'd0);
            5'd6: w = uc_raw(1'b0, 4'h3, 8'd2);
            5'd7: w = uc_raw(1'b0, 4'h2, 8'd0);
            5'd8: w = uc_raw(1'b1, 4'h2, 8'd0);
            5'd9: w = uc_raw(1'b0, 4'h2, 8'd0);
            5'd10, 5'd11, 5'd12, 5'd13, 5'd14:
                w = uc_body(3'(addr - UA_INIT_BYTE), SRC_INIT, CMD_WAIT,
                            OP_LOOP, UA_INIT_BYTE, 3'd4);
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19:
                w = uc_body(3'(addr - UA_BYTE), SRC_REQ, 8'd0,
                            OP_END, UA_BYTE, 3'd0);
            5'd20, 5'd21, 5'd22, 5'd23, 5'd24:
                w = uc_body(3'(addr - UA_DEC), SRC_DIGIT, 8'd0,
                            OP_LOOP, UA_DEC, 3'd3);
            default: w.op = OP_END;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/lcdns_bcd.sv @@
`timescale 1ns / 1ps
module lcdns_bcd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [13:0] i_value,
    output logic        o_done,
    output logic [15:0] o_digits
);
    import lcdns_pkg::*;

    localparam logic [1:0] LAST_STEP = 2'd2;

    logic [13:0] r_rem, n_rem;
    logic [15:0] r_bcd, n_bcd;
    logic [1:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic [13:0] thr;
    logic [13:0] take;
    logic [3:0]  dig;
    logic [13:0] rest;

    // Largest multiple of the current digit weight that still fits in the remainder.
    always_comb begin
        thr  = '0;
        take = '0;
        dig  = 4'd0;
        for (int k = 1; k < 10; k++) begin
            case (r_step)
                2'd0:    thr = 14'(k * 1000);
                2'd1:    thr = 14'(k * 100);
                default: thr = 14'(k * 10);
            endcase
            if (r_rem >= thr) begin
                dig  = 4'(k);
                take = thr;
            end
        end
    end

    assign rest = r_rem - take;

    // Thousands, hundreds and tens leave one per cycle; what remains is the units digit.
    always_comb begin
        n_rem  = r_rem;
        n_bcd  = r_bcd;
        n_step = r_step;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = (i_value > DEC_MAX) ? DEC_MAX : i_value;
            n_bcd  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = rest;
            n_bcd  = {r_bcd[11:0], dig};
            n_step = r_step + 2'd1;
            if (r_step == LAST_STEP) begin
                n_bcd  = {r_bcd[7:0], dig, rest[3:0]};
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_bcd <= n_bcd;
    end

    assign o_done   = r_busy && (r_step == LAST_STEP);
    assign o_digits = r_bcd;

endmodule

@@ rtl/core/lcdns_useq.sv @@
`timescale 1ns / 1ps
module lcdns_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcdns_pkg::t_start i_start,
    input  lcdns_pkg::t_cfg i_cfg,
    input  logic [15:0]     i_digits,
    output logic            o_done,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output lcdns_pkg::t_rslt o_rsp
);
    import lcdns_pkg::*;

    logic       r_active, n_active;
    logic [4:0] r_pc, n_pc;
    logic [2:0] r_idx, n_idx;
    logic       r_rs, n_rs;
    logic [7:0] r_byte, n_byte;
    logic       r_ovalid, n_ovalid;
    t_rslt      r_rsp, n_rsp;

    t_uword     uw;
    logic       adv;
    logic       fin;
    logic [3:0] dig;
    logic [7:0] src_byte;
    logic [3:0] nib;

    assign uw  = uc_rom(r_pc);
    assign adv = r_active && (!r_ovalid || i_rsp_ready);

    // Final word of the program: an end, or a loop whose count is spent.
    assign fin = (uw.op == OP_END) || ((uw.op == OP_LOOP) && (r_idx == uw.lim));

    // Digit picked by the loop index, thousands first.
    always_comb begin
        case (r_idx[1:0])
            2'd0:    dig = i_digits[15:12];
            2'd1:    dig = i_digits[11:8];
            2'd2:    dig = i_digits[7:4];
            default: dig = i_digits[3:0];
        endcase
    end

    // Byte source selected by the control word.
    always_comb begin
        case (uw.src)
            SRC_INIT: begin
                case (r_idx)
                    3'd0:    src_byte = i_cfg.func_set;
                    3'd1:    src_byte = i_cfg.disp_ctrl;
                    3'd2:    src_byte = CMD_CLEAR;
                    3'd3:    src_byte = i_cfg.entry_mode;
                    default: src_byte = CMD_HOME;
                endcase
            end
            SRC_DIGIT: src_byte = ASCII_ZERO + {4'h0, dig};
            default:   src_byte = r_byte;
        endcase
    end

    always_comb begin
        case (uw.nsel)
            NS_HI:   nib = src_byte[7:4];
            NS_LO:   nib = src_byte[3:0];
            default: nib = uw.nconst;
        endcase
    end

    // Step counter, loop index and the output beat register.
    always_comb begin
        n_active = r_active;
        n_pc     = r_pc;
        n_idx    = r_idx;
        n_rs     = r_rs;
        n_byte   = r_byte;
        n_ovalid = r_ovalid && !i_rsp_ready;
        n_rsp    = r_rsp;
        if (adv) begin
            n_ovalid         = 1'b1;
            n_rsp.reg_select = r_rs;
            n_rsp.enable     = uw.en;
            n_rsp.nibble     = nib;
            n_rsp.hold_units = uw.hold;
            n_rsp.last       = fin;
            if (fin) begin
                n_active = 1'b0;
            end else if (uw.op == OP_LOOP) begin
                n_pc  = uw.target;
                n_idx = r_idx + 3'd1;
            end else begin
                n_pc = r_pc + 5'd1;
            end
        end
        if (i_start.go) begin
            n_active = 1'b1;
            n_pc     = i_start.entry;
            n_idx    = '0;
            n_rs     = i_start.rs;
            n_byte   = i_start.req_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_pc     <= '0;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_ovalid <= n_ovalid;
            r_pc     <= n_pc;
            r_idx    <= n_idx;
        end
        r_rs   <= n_rs;
        r_byte <= n_byte;
        r_rsp  <= n_rsp;
    end

    assign o_done      = adv && fin;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_rsp;

endmodule

@@ rtl/core/char_lcd_nibble_write_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// request   i_req_valid / o_req_ready  i_req (t_req)
// result    o_rsp_valid / i_rsp_ready  o_rsp (t_rslt)
// config    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One pin state leaves per cycle while the result side takes beats, driven by a
// microcoded step counter: init gives 35 beats, command/data/cursor 5, decimal 20.
// A decimal request first passes the digit extractor: thousands, hundreds, then tens with units.
// One request is in work at a time; the next is taken once the final beat is formed.
// Reset is synchronous and loads the three init commands with their defaults.
// A stalled result side holds the output register and freezes the step counter.
module char_lcd_nibble_write_sequencer_unit #(
    parameter int MAX_COLUMNS = lcdns_pkg::DEF_MAX_COLUMNS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lcdns_pkg::t_req   i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output lcdns_pkg::t_rslt  o_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);
    import lcdns_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_RUN  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_cfg        r_cfg;
    t_start      start;
    logic        acc;
    logic        bcd_start;
    logic        bcd_done;
    logic [15:0] digits;
    logic        seq_done;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.func_set   <= CMD_FUNC_RST;
            r_cfg.disp_ctrl  <= CMD_DISP_RST;
            r_cfg.entry_mode <= CMD_ENTRY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FUNC_SET:  r_cfg.func_set   <= i_cfg_data;
                CFG_DISP_CTRL: r_cfg.disp_ctrl  <= i_cfg_data;
                CFG_ENTRY:     r_cfg.entry_mode <= i_cfg_data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign acc         = i_req_valid && o_req_ready;
    assign bcd_start   = acc && (i_req.req_type == REQ_DEC);

    // Request decode and program launch.
    always_comb begin
        n_state        = r_state;
        start.go       = 1'b0;
        start.entry    = UA_BYTE;
        start.rs       = 1'b0;
        start.req_byte = i_req.byte_value;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_req.req_type)
                        REQ_INIT: begin
                            start.go    = 1'b1;
                            start.entry = UA_INIT;
                            n_state     = ST_RUN;
                        end
                        REQ_CMD, REQ_DATA: begin
                            start.go = 1'b1;
                            start.rs = (i_req.req_type == REQ_DATA);
                            n_state  = ST_RUN;
                        end
                        REQ_CURSOR: begin
                            if (i_req.column < 8'(MAX_COLUMNS)) begin
                                start.go       = 1'b1;
                                start.req_byte = CMD_HOME | i_req.column
                                               | (i_req.row ? CMD_ROW2 : 8'h00);
                                n_state        = ST_RUN;
                            end
                        end
                        REQ_DEC: n_state = ST_CONV;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    start.go    = 1'b1;
                    start.entry = UA_DEC;
                    start.rs    = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (seq_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    lcdns_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bcd_start),
        .i_value  (i_req.number),
        .o_done   (bcd_done),
        .o_digits (digits)
    );

    lcdns_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cfg       (r_cfg),
        .i_digits    (digits),
        .o_done      (seq_done),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

@@ rtl/core/lcdns_chk.sv @@
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_unit_defines.svh"
module lcdns_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             o_req_ready,
    input  lcdns_pkg::t_req  i_req,
    input  logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  lcdns_pkg::t_rslt o_rsp
);
    import lcdns_pkg::*;

    // Reset leaves no beat pending and the request side open.
    `LCDNS_CHK_RST(a_reset_clean, !i_rst_n |=> !o_rsp_valid && o_req_ready, "reset state")

    // A stalled result beat holds.
    `LCDNS_CHK(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "beat changed under stall")

    // An accepted init closes the request side.
    `LCDNS_CHK(a_init_busy, i_req_valid && o_req_ready && i_req.req_type == REQ_INIT |=> !o_req_ready, "init did not block")

    // The final pin state of a request has enable low.
    `LCDNS_CHK(a_last_en_low, o_rsp_valid && o_rsp.last |-> !o_rsp.enable, "last beat with enable high")

endmodule

bind char_lcd_nibble_write_sequencer_unit lcdns_chk u_lcdns_chk (.*);
